FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Standalone header; simulation builds get the checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// The condition is never true.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: rtl/spc_pkg.sv
// Types and constants of the space packet receive checker.
// No dependencies; used by spc_route and space_packet_receive_checker.
package spc_pkg;

    localparam int CLS_W     = 3;   // class index width, covers up to eight classes
    localparam int APID_W    = 11;
    localparam int SEQ_W     = 14;
    localparam int POS_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam int MASK_W    = 6;

    localparam logic [POS_W-1:0] POS_MAX       = '1;
    localparam logic [POS_W-1:0] HDR_BYTES     = 17'd6;
    localparam logic [POS_W-1:0] TRAILER_BYTES = 17'd4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] NUM_APID_REGS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONSUMER_MASK = 3'd6;

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [2:0] ST_DELIVERED   = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_LEN_ERR     = 3'd2;
    localparam logic [2:0] ST_CRC_ERR     = 3'd3;
    localparam logic [2:0] ST_UNROUTABLE  = 3'd4;
    localparam logic [2:0] ST_NO_CONSUMER = 3'd5;

    // identifier reset values; classes past the sixth are fixed at all ones
    localparam logic [APID_W-1:0] APID_RESET [8] = '{
        11'h001, 11'h010, 11'h011, 11'h020, 11'h030, 11'h040, 11'h7FF, 11'h7FF
    };

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        payload_byte;
        logic [CLS_W-1:0]  class_index;
        logic [2:0]        status;
        logic [APID_W-1:0] packet_apid;
        logic [SEQ_W-1:0]  packet_seq;
        logic [1:0]        seq_flags_out;
        logic [2:0]        version_out;
        logic              packet_type;
        logic              secondary_present;
        logic              sequence_gap;
        logic [SEQ_W-1:0]  expected_seq;
    } result_t;

    // identifier lookup outcome
    typedef struct packed {
        logic             found;
        logic [CLS_W-1:0] idx;
        logic             consumer;
    } route_t;

endpackage

FILE: rtl/space_packet_receive_checker.sv
// Top level of the space packet receive checker: header parse, CRC-32, length,
// routing and sequence checks, output register with skid stage.
// Depends on spc_pkg, spc_route and assert_macros.svh.
//
//   channel   direction  handshake                payload
//   item      in         item_valid / item_stall   item_data   (spc_pkg::item_t)
//   result    out        result_valid/result_stall result_data (spc_pkg::result_t)
//   cfg       in         cfg_wen                   cfg_index, cfg_wdata
//
// One byte is taken per cycle while item_stall is low; its result is registered in the output
// register, or in the skid stage while the output register is stalled. The CRC byte update and
// the identifier compares sit between the state registers and the output register.
// Reset clears packet and per-class sequence state and reloads the default identifiers.
// A stalled result holds in the output register; one more result fits the skid stage,
// and item_stall rises only while the skid stage is full.
`include "assert_macros.svh"

module space_packet_receive_checker #(
    parameter int NUM_CLASSES = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  spc_pkg::item_t                   item_data,
    output logic                             result_valid,
    input  logic                             result_stall,
    output spc_pkg::result_t                 result_data,
    input  logic                             cfg_wen,
    input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // packet state
    logic [47:0]               hdr_reg, hdr_next;
    logic [spc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [31:0]               crc_reg, crc_next;
    logic [31:0]               trl_reg, trl_next;

    // per-class sequence state
    logic                      seen_reg [NUM_CLASSES];
    logic [spc_pkg::SEQ_W-1:0] exp_reg  [NUM_CLASSES];

    // output stage
    logic             out_valid_reg, skid_valid_reg;
    spc_pkg::result_t out_reg, skid_reg;

    logic                      accept, last, in_hdr, fwd, res_valid, class_wr, out_free;
    logic [7:0]                b;
    logic [spc_pkg::POS_W-1:0] dfield_bytes, app_len, pos_off, total;
    logic [spc_pkg::SEQ_W-1:0] seq;
    logic [CIW-1:0]            cls;
    spc_pkg::route_t           route;
    spc_pkg::result_t          res;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'h0, d};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ spc_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    spc_route #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_route (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .apid      (hdr_reg[42:32]),
        .route     (route)
    );

    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !item_stall;
    assign b          = item_data.rx_byte;
    assign last       = item_data.end_of_packet;

    assign dfield_bytes = {1'b0, hdr_reg[15:0]} + 17'd1;
    assign app_len   = (dfield_bytes >= spc_pkg::TRAILER_BYTES) ?
                       dfield_bytes - spc_pkg::TRAILER_BYTES : '0;
    assign in_hdr    = pos_reg < spc_pkg::HDR_BYTES;
    assign pos_off   = pos_reg - spc_pkg::HDR_BYTES;
    assign fwd       = !last && !in_hdr && (pos_off < app_len);
    assign total     = (pos_reg == spc_pkg::POS_MAX) ? pos_reg : pos_reg + 17'd1;
    assign seq       = hdr_reg[29:16];
    assign cls       = route.idx[CIW-1:0];
    assign trl_next  = in_hdr ? trl_reg : {trl_reg[23:0], b};

    // result and class update
    always_comb
    begin
        res      = '0;
        class_wr = 1'b0;
        if (last && in_hdr)
        begin
            res.kind        = spc_pkg::KIND_STATUS;
            res.class_index = spc_pkg::CLS_W'(NUM_CLASSES);
            res.status      = spc_pkg::ST_LEN_ERR;
        end
        else
        begin
            res.kind              = last ? spc_pkg::KIND_STATUS : spc_pkg::KIND_BYTE;
            res.payload_byte      = last ? 8'h00 : b;
            res.class_index       = route.found ? route.idx : spc_pkg::CLS_W'(NUM_CLASSES);
            res.packet_apid       = hdr_reg[42:32];
            res.packet_seq        = seq;
            res.seq_flags_out     = hdr_reg[31:30];
            res.version_out       = hdr_reg[47:45];
            res.packet_type       = hdr_reg[44];
            res.secondary_present = hdr_reg[43];
            res.status            = spc_pkg::ST_DELIVERED;
            if (last)
            begin
                if (total != spc_pkg::HDR_BYTES + dfield_bytes)
                begin
                    res.status = spc_pkg::ST_LEN_ERR;
                end
                else if (dfield_bytes < spc_pkg::TRAILER_BYTES)
                begin
                    res.status = spc_pkg::ST_TOO_SHORT;
                end
                else if (trl_next != ~crc_reg)
                begin
                    res.status = spc_pkg::ST_CRC_ERR;
                end
                else if (!route.found)
                begin
                    res.status = spc_pkg::ST_UNROUTABLE;
                end
                else
                begin
                    class_wr         = 1'b1;
                    res.sequence_gap = seen_reg[cls] && (seq != exp_reg[cls]);
                    res.expected_seq = exp_reg[cls];
                    res.status       = route.consumer ? spc_pkg::ST_DELIVERED :
                                                        spc_pkg::ST_NO_CONSUMER;
                end
            end
        end
    end

    assign res_valid = accept && (fwd || last);

    // next packet state
    always_comb
    begin
        hdr_next = in_hdr ? {hdr_reg[39:0], b} : hdr_reg;
        crc_next = fwd ? crc_step(crc_reg, b) : crc_reg;
        pos_next = (pos_reg == spc_pkg::POS_MAX) ? pos_reg : pos_reg + 17'd1;
        if (last)
        begin
            // restart for the next packet
            hdr_next = '0;
            crc_next = '1;
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
            pos_reg <= '0;
            crc_reg <= '1;
            trl_reg <= '0;
        end
        else if (accept)
        begin
            hdr_reg <= hdr_next;
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            trl_reg <= last ? 32'h0 : trl_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                seen_reg[i] <= 1'b0;
                exp_reg[i]  <= '0;
            end
        end
        else if (accept && class_wr)
        begin
            // adopt the received count
            seen_reg[cls] <= 1'b1;
            exp_reg[cls]  <= seq + 14'd1;
        end
    end

    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    `ASSERT_NEVER(a_skid_behind_out, clk, rst_n, skid_valid_reg && !out_valid_reg)
    `ASSERT_NEXT(a_restart_after_last, clk, rst_n, accept && last, pos_reg == '0 && crc_reg == '1)
    `ASSERT_IMPLY(a_class_wr_routed, clk, rst_n, class_wr, last && !in_hdr && route.found)

endmodule

FILE: rtl/spc_route.sv
// Class identifier and consumer mask registers with the identifier lookup.
// Depends on spc_pkg.
module spc_route #(
    parameter int NUM_CLASSES = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [spc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [spc_pkg::APID_W-1:0]          apid,
    output spc_pkg::route_t                     route
);

    logic [spc_pkg::APID_W-1:0] apid_reg [NUM_CLASSES];
    logic [spc_pkg::MASK_W-1:0] mask_reg;
    logic [7:0]                 mask_ext;

    for (genvar gi = 0; gi < NUM_CLASSES; gi++) begin : g_apid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                apid_reg[gi] <= spc_pkg::APID_RESET[gi];
            end
            else if (cfg_wen && (gi < 6) && (cfg_index < spc_pkg::NUM_APID_REGS)
                     && (cfg_index == spc_pkg::CFG_IDX_W'(gi)))
            begin
                apid_reg[gi] <= cfg_wdata[spc_pkg::APID_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_wen && cfg_index == spc_pkg::REG_CONSUMER_MASK)
        begin
            mask_reg <= cfg_wdata[spc_pkg::MASK_W-1:0];
        end
    end

    assign mask_ext = {2'b00, mask_reg};

    // scan from the top so the lowest matching class wins
    always_comb
    begin
        route = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (apid_reg[i] == apid)
            begin
                route.found    = 1'b1;
                route.idx      = spc_pkg::CLS_W'(i);
                route.consumer = mask_ext[i];
            end
        end
    end

endmodule
